>>> hdl/pfr_pkg.sv
// Shared types and constants for the page frame replacement unit.
// No dependencies; used by the frame cell, the recency cell and the top level.
package pfr_pkg;

	localparam int PAGE_W = 8;
	localparam int MISS_W = 16;
	localparam int FIDX_W = 2;

	localparam logic [MISS_W-1:0] MISS_MAX = '1;

	typedef enum logic {
		KIND_REF   = 1'b0,
		KIND_CLEAR = 1'b1
	} kind_t;

	typedef enum logic {
		POLICY_FIFO = 1'b0,
		POLICY_LRU  = 1'b1
	} policy_t;

	// Control for one frame cell.
	typedef struct packed {
		logic clear;
		logic write;
	} frame_ctl_t;

	// Control for one recency list cell.
	typedef struct packed {
		logic clear;
		logic shift;
		logic load;
	} list_ctl_t;

endpackage

>>> hdl/page_frame_replacement.sv
// Page frame replacement unit: top level with frame cells and recency list cells.
// Depends on pfr_pkg, pfr_frame_cell and pfr_list_cell.
//
// Each start transaction carries a page reference or a clear. The unit takes
// a new transaction only while busy is low: the edge with start high and busy
// low captures it, busy is high for the following cycle while the frame cells
// compare tags and the recency cells shift, and done is high for exactly one
// cycle after that with the result on hit, frame_index, evicted_valid,
// evicted_page and miss_total. The result ports hold until the next done.
// The receiver cannot stall done; sample the result while done is high.
// The policy register (cfg_we/cfg_wdata, 0 = FIFO, 1 = LRU) may be written
// only while the unit is idle; it applies to the next reference. A clear
// empties all frames, returns the FIFO pointer to the top frame, zeroes the
// miss count and reports an all-zero result.
module page_frame_replacement #(
	parameter int FRAMES = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic [pfr_pkg::PAGE_W-1:0]    page_number,
	output logic                          done,
	output logic                          hit,
	output logic [pfr_pkg::FIDX_W-1:0]    frame_index,
	output logic                          evicted_valid,
	output logic [pfr_pkg::PAGE_W-1:0]    evicted_page,
	output logic [pfr_pkg::MISS_W-1:0]    miss_total,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata
);

	localparam int IW = $clog2(FRAMES);
	localparam int CW = $clog2(FRAMES + 1);

	// Captured transaction
	logic                       valid_s1;
	logic                       kind_s1;
	logic [pfr_pkg::PAGE_W-1:0] page_s1;

	// Block state outside the cells
	logic                       policy_q;
	logic [IW-1:0]              ptr_q;
	logic [CW-1:0]              fill_q;
	logic [pfr_pkg::MISS_W-1:0] miss_q;

	// Result registers
	logic                       done_q;
	logic                       hit_q;
	logic [pfr_pkg::FIDX_W-1:0] fidx_q;
	logic                       evv_q;
	logic [pfr_pkg::PAGE_W-1:0] evp_q;
	logic [pfr_pkg::MISS_W-1:0] miss_out_q;

	// Cell taps
	logic [FRAMES-1:0]          fvalid;
	logic [pfr_pkg::PAGE_W-1:0] ftag [FRAMES];
	logic [FRAMES-1:0]          fmatch;
	logic [FRAMES-1:0]          omatch;
	logic [pfr_pkg::PAGE_W-1:0] lentry [FRAMES];
	logic [FRAMES-1:0]          lraw;
	pfr_pkg::frame_ctl_t        fctl [FRAMES];
	pfr_pkg::list_ctl_t         lctl [FRAMES];

	// Step decode
	logic                       step_ref;
	logic                       step_clear;
	logic                       found;
	logic [IW-1:0]              hit_idx;
	logic                       have_empty;
	logic [IW-1:0]              empty_idx;
	logic [IW-1:0]              lru_idx;
	logic [IW-1:0]              victim;
	logic [IW-1:0]              frame_sel;
	logic                       evict;
	logic [pfr_pkg::PAGE_W-1:0] ev_page;
	logic [pfr_pkg::PAGE_W-1:0] list_key;
	logic                       lfound;
	logic [IW-1:0]              lpos;
	logic                       move;
	logic                       fill_load;
	logic                       miss_inc;
	logic [pfr_pkg::MISS_W-1:0] miss_next;
	logic [IW+1:0]              frame_ext;

	assign busy       = valid_s1;
	assign step_ref   = valid_s1 && (kind_s1 == pfr_pkg::KIND_REF);
	assign step_clear = valid_s1 && (kind_s1 == pfr_pkg::KIND_CLEAR);

	// Capture the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kind_s1 <= kind;
			page_s1 <= page_number;
		end
	end

	// Policy register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= pfr_pkg::POLICY_FIFO;
		end else if (cfg_we) begin
			policy_q <= cfg_wdata;
		end
	end

	// Frame cells
	for (genvar g = 0; g < FRAMES; g++) begin : g_frame
		pfr_frame_cell u_frame (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (fctl[g]),
			.wr_tag       (page_s1),
			.key_page     (page_s1),
			.key_oldest   (lentry[0]),
			.valid        (fvalid[g]),
			.tag          (ftag[g]),
			.page_match   (fmatch[g]),
			.oldest_match (omatch[g])
		);
	end

	// Recency list cells; the last one has no right-hand neighbor
	for (genvar g = 0; g < FRAMES; g++) begin : g_list
		logic [pfr_pkg::PAGE_W-1:0] right;
		if (g == FRAMES - 1) begin : g_end
			assign right = '0;
		end else begin : g_mid
			assign right = lentry[g+1];
		end
		pfr_list_cell u_list (
			.clk       (clk),
			.ctl       (lctl[g]),
			.load_page (page_s1),
			.right_in  (right),
			.key       (list_key),
			.entry     (lentry[g]),
			.key_match (lraw[g])
		);
	end

	// Frame selection: lowest hit, highest empty, lowest LRU match
	always_comb begin
		found      = |fmatch;
		have_empty = ~&fvalid;
		hit_idx    = '0;
		empty_idx  = '0;
		lru_idx    = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (fmatch[i]) begin
				hit_idx = IW'(i);
			end
			if (omatch[i]) begin
				lru_idx = IW'(i);
			end
		end
		for (int i = 0; i < FRAMES; i++) begin
			if (!fvalid[i]) begin
				empty_idx = IW'(i);
			end
		end
		victim    = (policy_q == pfr_pkg::POLICY_LRU) ? lru_idx : ptr_q;
		evict     = !found && !have_empty;
		ev_page   = ftag[victim];
		if (found) begin
			frame_sel = hit_idx;
		end else if (have_empty) begin
			frame_sel = empty_idx;
		end else begin
			frame_sel = victim;
		end
		list_key  = found ? page_s1 : ev_page;
	end

	// Recency list position of the key, first match within the filled part
	always_comb begin
		lfound = 1'b0;
		lpos   = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (lraw[i] && (CW'(i) < fill_q)) begin
				lfound = 1'b1;
				lpos   = IW'(i);
			end
		end
		move      = step_ref && lfound && (found || evict);
		fill_load = step_ref && !found && have_empty && (fill_q < CW'(FRAMES));
	end

	// Cell control: hit or eviction moves the key to the back, a fill appends
	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			fctl[i].clear = step_clear;
			fctl[i].write = step_ref && !found && (frame_sel == IW'(i));
			lctl[i].clear = step_clear;
			lctl[i].shift = move && (IW'(i) >= lpos) && (CW'(i + 1) < fill_q);
			lctl[i].load  = (move && (CW'(i + 1) == fill_q))
				|| (fill_load && (CW'(i) == fill_q));
		end
	end

	assign miss_inc  = step_ref && !found && (miss_q != pfr_pkg::MISS_MAX);
	assign miss_next = miss_inc ? miss_q + 1'b1 : miss_q;

	// FIFO pointer, fill count and miss counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= IW'(FRAMES - 1);
			fill_q <= '0;
			miss_q <= '0;
		end else if (step_clear) begin
			ptr_q  <= IW'(FRAMES - 1);
			fill_q <= '0;
			miss_q <= '0;
		end else begin
			if (step_ref && evict && (policy_q == pfr_pkg::POLICY_FIFO)) begin
				ptr_q <= (ptr_q == '0) ? IW'(FRAMES - 1) : ptr_q - 1'b1;
			end
			if (fill_load) begin
				fill_q <= fill_q + 1'b1;
			end
			miss_q <= miss_next;
		end
	end

	// Result registers; hold between transactions
	assign frame_ext = {2'b00, frame_sel};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_clear) begin
			hit_q      <= 1'b0;
			fidx_q     <= '0;
			evv_q      <= 1'b0;
			evp_q      <= '0;
			miss_out_q <= '0;
		end else if (step_ref) begin
			hit_q      <= found;
			fidx_q     <= frame_ext[pfr_pkg::FIDX_W-1:0];
			evv_q      <= evict;
			evp_q      <= evict ? ev_page : '0;
			miss_out_q <= miss_next;
		end
	end

	assign done          = done_q;
	assign hit           = hit_q;
	assign frame_index   = fidx_q;
	assign evicted_valid = evv_q;
	assign evicted_page  = evp_q;
	assign miss_total    = miss_out_q;

`ifndef ASSERT_OFF
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("captured transaction did not complete");

	a_fill_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(fvalid) == int'(fill_q))
		else $error("fill count disagrees with resident frames");

	a_evict_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done && evicted_valid |-> !hit)
		else $error("eviction reported on a hit");

	a_miss_out: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> miss_total == miss_q)
		else $error("reported miss count differs from counter");

	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		step_ref && evict |-> fill_q == CW'(FRAMES))
		else $error("eviction with frames not full");
`endif

endmodule

>>> hdl/pfr_frame_cell.sv
// One page frame: tag and valid bit with two tag comparators.
// Depends on pfr_pkg.
module pfr_frame_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pfr_pkg::frame_ctl_t           ctl,
	input  logic [pfr_pkg::PAGE_W-1:0]    wr_tag,
	input  logic [pfr_pkg::PAGE_W-1:0]    key_page,
	input  logic [pfr_pkg::PAGE_W-1:0]    key_oldest,
	output logic                          valid,
	output logic [pfr_pkg::PAGE_W-1:0]    tag,
	output logic                          page_match,
	output logic                          oldest_match
);

	logic                       valid_q;
	logic [pfr_pkg::PAGE_W-1:0] tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tag_q   <= '0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
			tag_q   <= '0;
		end else if (ctl.write) begin
			valid_q <= 1'b1;
			tag_q   <= wr_tag;
		end
	end

	assign valid        = valid_q;
	assign tag          = tag_q;
	assign page_match   = valid_q && (tag_q == key_page);
	assign oldest_match = valid_q && (tag_q == key_oldest);

endmodule

>>> hdl/pfr_list_cell.sv
// One entry of the recency list; shifts in from its right-hand neighbor.
// Depends on pfr_pkg.
module pfr_list_cell (
	input  logic                          clk,
	input  pfr_pkg::list_ctl_t            ctl,
	input  logic [pfr_pkg::PAGE_W-1:0]    load_page,
	input  logic [pfr_pkg::PAGE_W-1:0]    right_in,
	input  logic [pfr_pkg::PAGE_W-1:0]    key,
	output logic [pfr_pkg::PAGE_W-1:0]    entry,
	output logic                          key_match
);

	logic [pfr_pkg::PAGE_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			entry_q <= '0;
		end else if (ctl.load) begin
			entry_q <= load_page;
		end else if (ctl.shift) begin
			entry_q <= right_in;
		end
	end

	assign entry     = entry_q;
	assign key_match = (entry_q == key);

endmodule

>>> test/pfr_result_checker.sv
// Result checker for the page frame replacement unit: predicts and compares every result.
// Depends on pfr_pkg; instantiated by page_frame_replacement_tb beside the unit.
module pfr_result_checker
	import pfr_pkg::*;
#(
	parameter int FRAMES = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic              kind,
	input  logic [PAGE_W-1:0] page_number,
	input  logic              done,
	input  logic              hit,
	input  logic [FIDX_W-1:0] frame_index,
	input  logic              evicted_valid,
	input  logic [PAGE_W-1:0] evicted_page,
	input  logic [MISS_W-1:0] miss_total,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	output int                fail_count,
	output int                results_due
);

	localparam int PTR_W = $clog2(FRAMES);

	typedef struct packed {
		logic              hit;
		logic [FIDX_W-1:0] frame_index;
		logic              evicted_valid;
		logic [PAGE_W-1:0] evicted_page;
		logic [MISS_W-1:0] miss_total;
	} frame_outcome_t;

	logic [PAGE_W-1:0] frame_tag [FRAMES];
	logic              frame_valid [FRAMES];
	logic [PTR_W-1:0]  fifo_ptr;
	logic [PAGE_W-1:0] recency [FRAMES];	// oldest first, fill_level entries
	int                fill_level;
	logic [MISS_W-1:0] misses;
	policy_t           policy;

	frame_outcome_t outcomes_due [$];
	frame_outcome_t want, got;
	int mismatches = 0;
	int results_seen = 0;

	task automatic clear_frames();
		for (int i = 0; i < FRAMES; i++) begin
			frame_tag[i] = '0;
			frame_valid[i] = 1'b0;
			recency[i] = '0;
		end
		fifo_ptr = PTR_W'(FRAMES - 1);
		fill_level = 0;
		misses = '0;
	endtask

	function automatic int recency_pos(input logic [PAGE_W-1:0] pg);
		for (int i = 0; i < fill_level; i++)
			if (recency[i] == pg)
				return i;
		return FRAMES;
	endfunction

	// Drop the entry at pos and append pg as the newest.
	task automatic recency_to_back(input int pos, input logic [PAGE_W-1:0] pg);
		if (fill_level == 0 || pos >= fill_level)
			return;
		for (int i = pos + 1; i < fill_level; i++)
			recency[i-1] = recency[i];
		recency[fill_level-1] = pg;
	endtask

	task automatic resolve_reference(input kind_t k, input logic [PAGE_W-1:0] pg,
			output frame_outcome_t o);
		int slot;
		int empty_slot;
		bit found;
		bit have_empty;
		logic [PAGE_W-1:0] oldest;
		o = '0;
		slot = 0;
		empty_slot = 0;
		found = 1'b0;
		have_empty = 1'b0;
		if (k == KIND_CLEAR) begin
			clear_frames();
			return;
		end
		for (int i = 0; i < FRAMES; i++) begin
			if (frame_valid[i] && frame_tag[i] == pg && !found) begin
				found = 1'b1;
				slot = i;
			end
			if (!frame_valid[i]) begin
				have_empty = 1'b1;
				empty_slot = i;
			end
		end
		if (found) begin
			o.hit = 1'b1;
			recency_to_back(recency_pos(pg), pg);
		end else begin
			if (misses != MISS_MAX)
				misses++;
			if (have_empty) begin
				slot = empty_slot;
				frame_tag[slot] = pg;
				frame_valid[slot] = 1'b1;
				if (fill_level < FRAMES) begin
					recency[fill_level] = pg;
					fill_level++;
				end
			end else begin
				if (policy == POLICY_FIFO) begin
					slot = fifo_ptr;
					fifo_ptr = (fifo_ptr == 0) ? PTR_W'(FRAMES - 1) : fifo_ptr - 1'b1;
				end else begin
					oldest = recency[0];
					slot = 0;
					for (int i = FRAMES - 1; i >= 0; i--)
						if (frame_valid[i] && frame_tag[i] == oldest)
							slot = i;
				end
				o.evicted_valid = 1'b1;
				o.evicted_page = frame_tag[slot];
				recency_to_back(recency_pos(frame_tag[slot]), pg);
				frame_tag[slot] = pg;
			end
		end
		o.frame_index = FIDX_W'(slot);
		o.miss_total = misses;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			clear_frames();
			policy = POLICY_FIFO;
			outcomes_due.delete();
		end else begin
			if (cfg_we)
				policy = policy_t'(cfg_wdata);
			// a result strobe always belongs to an older transaction than one taken now
			if (done) begin
				got = '{hit, frame_index, evicted_valid, evicted_page, miss_total};
				results_seen++;
				if (outcomes_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d unexpected: hit=%0b frame=%0d evicted=%0b/%02h misses=%0d",
							results_seen, got.hit, got.frame_index, got.evicted_valid,
							got.evicted_page, got.miss_total);
				end else begin
					want = outcomes_due.pop_front();
					if (got.hit !== want.hit || got.frame_index !== want.frame_index ||
							got.evicted_valid !== want.evicted_valid ||
							got.evicted_page !== want.evicted_page ||
							got.miss_total !== want.miss_total) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d mismatch: expected hit=%0b frame=%0d evicted=%0b/%02h misses=%0d, got hit=%0b frame=%0d evicted=%0b/%02h misses=%0d",
								results_seen, want.hit, want.frame_index, want.evicted_valid,
								want.evicted_page, want.miss_total, got.hit, got.frame_index,
								got.evicted_valid, got.evicted_page, got.miss_total);
					end
				end
			end
			if (start && !busy) begin
				resolve_reference(kind_t'(kind), page_number, want);
				outcomes_due.push_back(want);
			end
		end
		fail_count <= mismatches;
		results_due <= outcomes_due.size();
	end

endmodule

>>> test/page_frame_replacement_tb.sv
// Testbench top for the page frame replacement unit: clock, reset, stimulus and verdict.
// Depends on pfr_pkg, page_frame_replacement and pfr_result_checker.
module page_frame_replacement_tb;
	import pfr_pkg::*;

	localparam int FRAMES       = 4;
	localparam int RANDOM_ITEMS = 1830;
	// cycles with no transaction and no result before the run is declared hung
	localparam int STALL_LIMIT  = 1000;

	logic              clk;
	logic              arst_n      = 1'b0;
	logic              start       = 1'b0;
	logic              kind        = KIND_REF;
	logic [PAGE_W-1:0] page_number = '0;
	logic              cfg_we      = 1'b0;
	logic              cfg_wdata   = POLICY_FIFO;
	logic              busy;
	logic              done;
	logic              hit;
	logic [FIDX_W-1:0] frame_index;
	logic              evicted_valid;
	logic [PAGE_W-1:0] evicted_page;
	logic [MISS_W-1:0] miss_total;

	int mismatches;
	int results_due;
	int burst_left = 0;
	int idle_cycles = 0;
	int sent = 0;
	policy_t cur_policy = POLICY_FIFO;

	page_frame_replacement #(
		.FRAMES(FRAMES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.page_number  (page_number),
		.done         (done),
		.hit          (hit),
		.frame_index  (frame_index),
		.evicted_valid(evicted_valid),
		.evicted_page (evicted_page),
		.miss_total   (miss_total),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	pfr_result_checker #(
		.FRAMES(FRAMES)
	) chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.page_number  (page_number),
		.done         (done),
		.hit          (hit),
		.frame_index  (frame_index),
		.evicted_valid(evicted_valid),
		.evicted_page (evicted_page),
		.miss_total   (miss_total),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.fail_count   (mismatches),
		.results_due  (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: count cycles in which neither a transaction nor a result moves.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Present one transaction and hold it until the unit takes it. Leave start
	// high afterwards so a following transaction goes out back to back.
	task automatic send(input kind_t k, input logic [PAGE_W-1:0] pg);
		start <= 1'b1;
		kind <= k;
		page_number <= pg;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic idle_for(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Sender pacing: bursts of random length, random gaps between them, and
	// now and then a long stretch with no gap at all.
	task automatic pace();
		if (burst_left == 0) begin
			if ($urandom_range(0, 7) == 0)
				burst_left = 80;
			else
				burst_left = $urandom_range(1, 20);
			idle_for($urandom_range(1, 12));
		end
		burst_left--;
	endtask

	// Drop start and wait until every outstanding result has come back. The
	// count from the checker is registered, so wait for a clock edge before looking at it.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Call only with the unit idle, i.e. right after settle().
	task automatic write_policy(input policy_t p);
		cfg_we <= 1'b1;
		cfg_wdata <= p;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		cur_policy = p;
	endtask

	initial begin
		logic [PAGE_W-1:0] pool [8];
		int pool_size;
		int phase_len;
		int pick;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Policy is left at its reset value (FIFO) first.
		// Fill all frames from empty, highest frame first; page 0 must miss even
		// though the tags come out of reset as zero.
		send(KIND_REF, 8'h00);
		send(KIND_REF, 8'hFF);
		send(KIND_REF, 8'h00);
		send(KIND_REF, 8'h55);
		send(KIND_REF, 8'hAA);
		// FIFO evictions walk the pointer down from the top frame and wrap
		send(KIND_REF, 8'h0F);
		send(KIND_REF, 8'h0F);
		send(KIND_REF, 8'hF0);
		send(KIND_REF, 8'hFF);
		send(KIND_REF, 8'h01);
		send(KIND_REF, 8'h02);
		// a clear ignores its page number; clear twice in a row too
		send(KIND_CLEAR, 8'hFF);
		send(KIND_CLEAR, 8'h00);
		send(KIND_REF, 8'h80);
		send(KIND_REF, 8'h01);
		send(KIND_REF, 8'h80);
		send(KIND_REF, 8'h02);
		send(KIND_REF, 8'h03);
		// switch to LRU with every frame full: the state carries over and the
		// recency list kept in FIFO mode picks the victims
		settle();
		write_policy(POLICY_LRU);
		send(KIND_REF, 8'h04);
		send(KIND_REF, 8'h80);
		send(KIND_REF, 8'h05);
		send(KIND_REF, 8'h03);
		send(KIND_REF, 8'h06);
		// and back to FIFO mid-stream
		settle();
		write_policy(POLICY_FIFO);
		send(KIND_REF, 8'h07);
		send(KIND_REF, 8'h04);

		// Random part: phases with a fresh policy setting and a small page pool,
		// so hits, refills and evictions all happen often. Mix in pages from the
		// whole range and the occasional clear.
		while (sent < RANDOM_ITEMS) begin
			settle();
			if ($urandom_range(0, 3) == 0)
				write_policy(cur_policy);
			else
				write_policy(cur_policy == POLICY_FIFO ? POLICY_LRU : POLICY_FIFO);
			pool_size = $urandom_range(3, 8);
			foreach (pool[i])
				pool[i] = PAGE_W'($urandom_range(0, 255));
			if ($urandom_range(0, 2) == 0) begin
				pool[0] = '0;
				pool[1] = '1;
			end
			phase_len = $urandom_range(80, 220);
			for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
				pace();
				pick = $urandom_range(0, 99);
				if (pick < 3)
					send(KIND_CLEAR, PAGE_W'($urandom_range(0, 255)));
				else if (pick < 15)
					send(KIND_REF, PAGE_W'($urandom_range(0, 255)));
				else
					send(KIND_REF, pool[$urandom_range(0, pool_size - 1)]);
				sent++;
			end
		end

		// Closing part: clear under a random policy, refill a little, clear again.
		settle();
		write_policy($urandom_range(0, 1) ? POLICY_LRU : POLICY_FIFO);
		send(KIND_CLEAR, 8'h00);
		send(KIND_REF, 8'h00);
		send(KIND_REF, 8'h00);
		send(KIND_CLEAR, 8'hFF);
		send(KIND_REF, 8'h10);

		settle();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && results_due == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
